// ===== hw/rtl/wnad_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wnad_pkg
// Shared constants, types and register indexes of the agreement detector.
// ---------------------------------------------------------------------------
package wnad_pkg;

    localparam int NEIGHBORS    = 4;
    localparam int WINDOW_DEPTH = 8;
    localparam int VALUE_COUNT  = 16;

    localparam int VAL_W    = 4;
    localparam int ACT_W    = 3;
    localparam int NODE_W   = 10;
    localparam int ROUND_W  = 16;
    localparam int CNT_W    = 4;
    localparam int LANE_W   = $clog2(NEIGHBORS);
    localparam int SLOT_W   = $clog2(WINDOW_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int REC_DEPTH = 4;
    localparam int REC_PTR_W = $clog2(REC_DEPTH);
    localparam int REC_CNT_W = REC_PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE  = 2'd0,
        CFG_THRESH  = 2'd1,
        CFG_NODE_ID = 2'd2
    } t_cfg_idx;

    typedef logic [NEIGHBORS-1:0][VAL_W-1:0] t_lanes;

    // One round's trigger candidates, one per lane in order of the lanes.
    typedef struct packed {
        logic [NEIGHBORS-1:0][VAL_W-1:0]     value;
        logic [NEIGHBORS-1:0][NEIGHBORS-1:0] mask;
        logic [NEIGHBORS-1:0]                pass;
        logic [ROUND_W-1:0]                  round;
    } t_rec;

endpackage
`default_nettype wire

// ===== hw/rtl/wnad_in_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wnad_in_if
// Input channel: one round of lane values per item.
// ---------------------------------------------------------------------------
interface wnad_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] value_lane0;
    logic [3:0] value_lane1;
    logic [3:0] value_lane2;
    logic [3:0] value_lane3;

    modport source (output valid, value_lane0, value_lane1, value_lane2, value_lane3,
                    input ready);
    modport sink (input valid, value_lane0, value_lane1, value_lane2, value_lane3,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wnad_out_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wnad_out_if
// Output channel: one trigger report per item.
// ---------------------------------------------------------------------------
interface wnad_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  agreed_value;
    logic [3:0]  neighbor_mask;
    logic [15:0] round_number;
    logic [9:0]  reporter_id;
    logic        last_trigger;

    modport source (output valid, agreed_value, neighbor_mask, round_number, reporter_id,
                    last_trigger, input ready);
    modport sink (input valid, agreed_value, neighbor_mask, round_number, reporter_id,
                  last_trigger, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wnad_emit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wnad_emit
// Queue of per-round candidate records, drained one trigger per cycle while the output is ready.
// ---------------------------------------------------------------------------
module wnad_emit import wnad_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_rec                 i_rec,
    input  logic [NODE_W-1:0]    i_node_id,
    output logic [REC_CNT_W-1:0] o_fill,
    wnad_out_if.source           o_out
);

    t_rec                 r_mem [REC_DEPTH];
    logic [REC_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [REC_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [REC_CNT_W-1:0] r_fill, n_fill;
    logic [LANE_W-1:0]    r_idx, n_idx;

    t_rec                 head;
    logic [NEIGHBORS-1:0] rem;
    logic [LANE_W-1:0]    sel;
    logic                 found;
    logic                 more;
    logic                 fire;
    logic                 pop;

    always_comb begin
        head  = r_mem[r_rd_ptr];
        sel   = '0;
        found = 1'b0;
        more  = 1'b0;
        for (int k = 0; k < NEIGHBORS; k++) begin
            rem[k] = head.pass[k] && (LANE_W'(k) >= r_idx);
        end
        for (int k = 0; k < NEIGHBORS; k++) begin
            if (rem[k] && !found) begin
                sel   = LANE_W'(k);
                found = 1'b1;
            end
        end
        for (int k = 0; k < NEIGHBORS; k++) begin
            if (rem[k] && (LANE_W'(k) > sel)) begin
                more = 1'b1;
            end
        end
    end

    assign o_out.valid         = (r_fill != '0) && found;
    assign o_out.agreed_value  = head.value[sel];
    assign o_out.neighbor_mask = head.mask[sel];
    assign o_out.round_number  = head.round;
    assign o_out.reporter_id   = i_node_id;
    assign o_out.last_trigger  = !more;

    assign fire = o_out.valid && o_out.ready;
    // A record with no trigger left is dropped without showing anything.
    assign pop  = (r_fill != '0) && (!found || (fire && !more));

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill + REC_CNT_W'(i_push) - REC_CNT_W'(pop);
        priority if (pop) begin
            n_idx = '0;
        end else if (fire) begin
            n_idx = sel + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_idx    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    assign o_fill = r_fill;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_fill < REC_CNT_W'(REC_DEPTH)))
        else $error("record queue overflow");

    a_fire_pops_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && o_out.last_trigger && !i_push) |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("last trigger did not retire its record");

endmodule
`default_nettype wire

// ===== hw/rtl/windowed_neighbor_agreement_detector.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// windowed_neighbor_agreement_detector
// Per-lane sliding windows of reported values with agreement triggers.
// ---------------------------------------------------------------------------
// Flow: a new round is taken while the last lane of the previous round is
// written back; triggers of a round follow one per cycle while the output
// is ready. The count memory, which paces the rounds, takes one
// read-modify-write of a lane's row per cycle, lane after lane.
// Reset: registers return to their reset values and the count rows are marked
// invalid at once (an invalid row reads as all zero); no clearing pass.
module windowed_neighbor_agreement_detector import wnad_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wnad_in_if.sink               i_in,
    wnad_out_if.source            o_out
);

    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(NEIGHBORS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
    localparam int                ROW_W     = VALUE_COUNT * CNT_W;

    // Configuration registers.
    logic [ACT_W-1:0]  r_active;
    logic [ACT_W-1:0]  r_thresh;
    logic [NODE_W-1:0] r_node_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= ACT_W'(4);
            r_thresh  <= ACT_W'(3);
            r_node_id <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACTIVE:  r_active  <= i_cfg_data[ACT_W-1:0];
                CFG_THRESH:  r_thresh  <= i_cfg_data[ACT_W-1:0];
                CFG_NODE_ID: r_node_id <= i_cfg_data[NODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input side. A round is taken when no round is in flight or while the last
    // lane of the previous round is being written back, as long as the record
    // queue has room for every round still in flight.
    t_lanes               in_vals;
    logic                 in_fire;
    logic [REC_CNT_W-1:0] q_fill;
    logic [REC_CNT_W:0]   q_need;

    logic [SLOT_W-1:0]  r_slot;
    logic               r_full;
    logic [ROUND_W-1:0] r_round;

    logic               r_rmw_v;
    logic [LANE_W-1:0]  r_rmw_lane;
    t_lanes             r_vals;
    logic               r_job_full;
    logic [ROUND_W-1:0] r_job_round;

    logic               r_rec_v;
    t_lanes             r_rec_vals;
    logic [ROUND_W-1:0] r_rec_round;

    assign in_vals = {i_in.value_lane3, i_in.value_lane2, i_in.value_lane1, i_in.value_lane0};
    assign q_need  = (REC_CNT_W+1)'(q_fill) + (REC_CNT_W+1)'(r_rmw_v)
                   + (REC_CNT_W+1)'(r_rec_v);
    assign i_in.ready = (!r_rmw_v || (r_rmw_lane == LANE_LAST))
                      && (q_need < (REC_CNT_W+1)'(REC_DEPTH));
    assign in_fire = i_in.valid && i_in.ready;

    // Window memory: one row per slot holding every lane's value. The old row
    // is read out in the same cycle that the new one is written.
    logic [NEIGHBORS*VAL_W-1:0] r_win_mem [WINDOW_DEPTH];
    t_lanes                     r_old_row;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_win_mem[r_slot] <= in_vals;
            r_old_row         <= r_win_mem[r_slot];
        end
    end

    // Count memory: one row per lane with a count for every value. Each lane
    // is read one cycle and written back the next, so the write and the read
    // in any cycle always touch different rows.
    logic [ROW_W-1:0]     r_cnt_mem [NEIGHBORS];
    logic [ROW_W-1:0]     r_cnt_row;
    logic                 r_cnt_row_vld;
    logic [NEIGHBORS-1:0] r_row_valid;
    logic                 cnt_rd_en;
    logic [LANE_W-1:0]    cnt_rd_addr;

    always_comb begin
        cnt_rd_en   = in_fire || (r_rmw_v && (r_rmw_lane != LANE_LAST));
        cnt_rd_addr = in_fire ? '0 : r_rmw_lane + 1'b1;
    end

    // Row update: drop the value leaving the window once it is full, then add
    // the newcomer. A nonzero flag per value mirrors every row.
    logic [ROW_W-1:0]       row_in;
    logic [ROW_W-1:0]       n_row;
    logic [VALUE_COUNT-1:0] n_flags;
    logic [VAL_W-1:0]       old_val;
    logic [VAL_W-1:0]       new_val;
    logic [CNT_W-1:0]       cnt;

    always_comb begin
        row_in  = r_cnt_row_vld ? r_cnt_row : '0;
        old_val = r_old_row[r_rmw_lane];
        new_val = r_vals[r_rmw_lane];
        n_row   = '0;
        n_flags = '0;
        cnt     = '0;
        for (int v = 0; v < VALUE_COUNT; v++) begin
            cnt = row_in[v*CNT_W +: CNT_W];
            if (r_job_full && (old_val == VAL_W'(v)) && (cnt != '0)) begin
                cnt = cnt - 1'b1;
            end
            if (new_val == VAL_W'(v)) begin
                cnt = cnt + 1'b1;
            end
            n_row[v*CNT_W +: CNT_W] = cnt;
            n_flags[v]              = (cnt != '0);
        end
    end

    logic [VALUE_COUNT-1:0] r_flags [NEIGHBORS];

    always_ff @(posedge i_clk) begin
        if (r_rmw_v) begin
            r_cnt_mem[r_rmw_lane] <= n_row;
        end
        if (cnt_rd_en) begin
            r_cnt_row <= r_cnt_mem[cnt_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid   <= '0;
            r_cnt_row_vld <= 1'b0;
            for (int j = 0; j < NEIGHBORS; j++) begin
                r_flags[j] <= '0;
            end
        end else begin
            if (cnt_rd_en) begin
                r_cnt_row_vld <= r_row_valid[cnt_rd_addr];
            end
            if (r_rmw_v) begin
                r_row_valid[r_rmw_lane] <= 1'b1;
                r_flags[r_rmw_lane]     <= n_flags;
            end
        end
    end

    // Round sequencing: slot pointer, window fill and round counter advance on
    // every accepted item; the lane counter walks the count rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_full     <= 1'b0;
            r_round    <= '0;
            r_rmw_v    <= 1'b0;
            r_rmw_lane <= '0;
            r_rec_v    <= 1'b0;
        end else begin
            r_rec_v <= r_rmw_v && (r_rmw_lane == LANE_LAST);
            if (in_fire) begin
                r_slot     <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                r_full     <= r_full || (r_slot == SLOT_LAST);
                r_round    <= r_round + 1'b1;
                r_rmw_v    <= 1'b1;
                r_rmw_lane <= '0;
            end else if (r_rmw_v) begin
                r_rmw_v    <= (r_rmw_lane != LANE_LAST);
                r_rmw_lane <= r_rmw_lane + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_vals      <= in_vals;
            r_job_full  <= r_full;
            r_job_round <= r_round;
        end
        if (r_rmw_v && (r_rmw_lane == LANE_LAST)) begin
            r_rec_vals  <= r_vals;
            r_rec_round <= r_job_round;
        end
    end

    // Candidate evaluation, in the cycle after the last lane is written back
    // and before the next round touches any flags. Lane k's value is a
    // candidate when no lower active lane reported the same value.
    logic [ACT_W-1:0]     act;
    logic [NEIGHBORS-1:0] in_act;
    logic [NEIGHBORS-1:0] distinct;
    logic [ACT_W-1:0]     agree;
    t_rec                 rec;

    always_comb begin
        act   = (r_active > ACT_W'(NEIGHBORS)) ? ACT_W'(NEIGHBORS) : r_active;
        rec   = '0;
        agree = '0;
        for (int k = 0; k < NEIGHBORS; k++) begin
            in_act[k] = (ACT_W'(k) < act);
        end
        for (int k = 0; k < NEIGHBORS; k++) begin
            distinct[k] = in_act[k];
            for (int j = 0; j < k; j++) begin
                if (r_rec_vals[j] == r_rec_vals[k]) begin
                    distinct[k] = 1'b0;
                end
            end
        end
        for (int k = 0; k < NEIGHBORS; k++) begin
            rec.value[k] = r_rec_vals[k];
            for (int j = 0; j < NEIGHBORS; j++) begin
                rec.mask[k][j] = in_act[j] && r_flags[j][r_rec_vals[k]];
            end
            agree       = ACT_W'($countones(rec.mask[k]));
            rec.pass[k] = distinct[k] && (agree >= r_thresh);
        end
        rec.round = r_rec_round;
    end

    wnad_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (r_rec_v),
        .i_rec     (rec),
        .i_node_id (r_node_id),
        .o_fill    (q_fill),
        .o_out     (o_out)
    );

    a_accept_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (!r_rmw_v || (r_rmw_lane == LANE_LAST)))
        else $error("item accepted while count rows were still busy");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_rmw_v && (r_rmw_lane == '0)))
        else $error("accepted item did not start at lane zero");

    a_rec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_v |=> !r_rec_v)
        else $error("two records evaluated in consecutive cycles");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed neighbor agreement detector: rounds
// of lane values go in, every trigger report is predicted and compared.
// ---------------------------------------------------------------------------
module tb_top;
    import wnad_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [3:0] lane [NEIGHBORS];
    } t_round;

    typedef struct {
        logic [3:0]  agreed_value;
        logic [3:0]  neighbor_mask;
        logic [15:0] round_number;
        logic [9:0]  reporter_id;
        logic        last_trigger;
    } t_trigger;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    wnad_in_if  in_ch ();
    wnad_out_if out_ch ();

    windowed_neighbor_agreement_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // Predictor state: a private copy of the windows, per-lane value counts
    // and the registers, kept in step with every round the block accepts.
    logic [3:0]  win_hist [NEIGHBORS][WINDOW_DEPTH];
    int          lane_count [NEIGHBORS][VALUE_COUNT];
    int          next_slot;
    bit          hist_full;
    logic [15:0] round_idx;
    int          cfg_active;
    int          cfg_thresh;
    logic [9:0]  cfg_node;

    t_round   pending_rounds [$];
    t_trigger expected_triggers [$];

    int  error_count;
    int  rounds_accepted;
    int  triggers_seen;
    int  idle_cycles;
    bit  stim_done;
    int  hold_req;          // bumped by the stimulus to ask for a long stall
    int  hold_served = 0;   // stall requests the receiver has taken up
    int  hold_left = 0;     // cycles of the current stall still to go
    int  in_gap;
    int  out_gap;
    bit  in_taken;          // a round was accepted at the last rising edge
    bit  out_taken;         // a report was accepted at the last rising edge

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Work out the triggers of one round and update the windows, the way the
    // block does: remove the oldest value once the window is full, add the
    // new one, then test each distinct active value in lane order.
    task automatic predict_round(input t_round r);
        int act;
        int distinct [$];
        int mask;
        int agree;
        int first_new;
        t_trigger t;
        act = (cfg_active > NEIGHBORS) ? NEIGHBORS : cfg_active;
        if (hist_full) begin
            for (int i = 0; i < NEIGHBORS; i++) begin
                if (lane_count[i][win_hist[i][next_slot]] > 0)
                    lane_count[i][win_hist[i][next_slot]]--;
            end
        end
        for (int i = 0; i < NEIGHBORS; i++) begin
            win_hist[i][next_slot] = r.lane[i];
            lane_count[i][r.lane[i]]++;
            if (i < act) begin
                first_new = 1;
                foreach (distinct[k]) if (distinct[k] == r.lane[i]) first_new = 0;
                if (first_new) distinct.push_back(r.lane[i]);
            end
        end
        first_new = expected_triggers.size();
        foreach (distinct[k]) begin
            mask  = 0;
            agree = 0;
            for (int j = 0; j < act; j++) begin
                if (lane_count[j][distinct[k]] > 0) begin
                    agree++;
                    mask |= 1 << j;
                end
            end
            if (agree >= cfg_thresh) begin
                t.agreed_value  = distinct[k][3:0];
                t.neighbor_mask = mask[3:0];
                t.round_number  = round_idx;
                t.reporter_id   = cfg_node;
                t.last_trigger  = 1'b0;
                expected_triggers.push_back(t);
            end
        end
        // The final trigger of the round carries the last flag.
        if (expected_triggers.size() > first_new)
            expected_triggers[expected_triggers.size()-1].last_trigger = 1'b1;
        next_slot++;
        if (next_slot >= WINDOW_DEPTH) begin
            next_slot = 0;
            hist_full = 1;
        end
        round_idx++;
    endtask

    // Handshakes are recorded at the rising edge where they happen, so that
    // the falling-edge processes see them even after ready or valid moved.
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && in_ch.valid && in_ch.ready;
        out_taken <= i_rst_n && out_ch.valid && out_ch.ready;
    end

    // Driver: inputs change on the falling edge only. Each round waits a
    // random gap before it is offered; valid stays high across back-to-back
    // rounds without being lowered in between.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_taken) begin
            // accepted at the last rising edge; move on to the next round
            void'(pending_rounds.pop_front());
            in_gap = $urandom_range(0, 8);
            if (in_gap == 0 && pending_rounds.size() > 0) begin
                in_ch.value_lane0 <= pending_rounds[0].lane[0];
                in_ch.value_lane1 <= pending_rounds[0].lane[1];
                in_ch.value_lane2 <= pending_rounds[0].lane[2];
                in_ch.value_lane3 <= pending_rounds[0].lane[3];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end else if (!in_ch.valid) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_rounds.size() > 0) begin
                in_ch.valid       <= 1'b1;
                in_ch.value_lane0 <= pending_rounds[0].lane[0];
                in_ch.value_lane1 <= pending_rounds[0].lane[1];
                in_ch.value_lane2 <= pending_rounds[0].lane[2];
                in_ch.value_lane3 <= pending_rounds[0].lane[3];
            end
        end
    end

    // Receiver back-pressure: a random stall before each report, or a long
    // hold, counted here, whenever the stimulus asks for one.
    always @(negedge i_clk) begin
        if (hold_req != hold_served) begin
            hold_served = hold_req;
            hold_left   = HOLD_CYCLES;
        end
        if (!i_rst_n || hold_left > 0) begin
            out_ch.ready <= 1'b0;
            out_gap = $urandom_range(0, 8);
            if (hold_left > 0) hold_left--;
        end else if (out_taken) begin
            out_gap = $urandom_range(0, 8);
            out_ch.ready <= (out_gap == 0);
        end else if (out_gap > 0) begin
            out_gap--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: sample both channels at the rising edge. Accepted rounds feed
    // the predictor; accepted reports are checked against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_ch.valid && in_ch.ready) begin
                t_round r;
                r.lane[0] = in_ch.value_lane0;
                r.lane[1] = in_ch.value_lane1;
                r.lane[2] = in_ch.value_lane2;
                r.lane[3] = in_ch.value_lane3;
                predict_round(r);
                rounds_accepted++;
            end
            if (out_ch.valid && out_ch.ready) begin
                triggers_seen++;
                if (expected_triggers.size() == 0) begin
                    $display("%0t: unexpected trigger value=%0d mask=%0h round=%0d",
                             $time, out_ch.agreed_value, out_ch.neighbor_mask,
                             out_ch.round_number);
                    error_count++;
                end else begin
                    t_trigger e;
                    e = expected_triggers.pop_front();
                    if (out_ch.agreed_value !== e.agreed_value) begin
                        $display("%0t: agreed_value expected %0d actual %0d",
                                 $time, e.agreed_value, out_ch.agreed_value);
                        error_count++;
                    end
                    if (out_ch.neighbor_mask !== e.neighbor_mask) begin
                        $display("%0t: neighbor_mask expected %0h actual %0h",
                                 $time, e.neighbor_mask, out_ch.neighbor_mask);
                        error_count++;
                    end
                    if (out_ch.round_number !== e.round_number) begin
                        $display("%0t: round_number expected %0d actual %0d",
                                 $time, e.round_number, out_ch.round_number);
                        error_count++;
                    end
                    if (out_ch.reporter_id !== e.reporter_id) begin
                        $display("%0t: reporter_id expected %0d actual %0d",
                                 $time, e.reporter_id, out_ch.reporter_id);
                        error_count++;
                    end
                    if (out_ch.last_trigger !== e.last_trigger) begin
                        $display("%0t: last_trigger expected %0b actual %0b",
                                 $time, e.last_trigger, out_ch.last_trigger);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d reports still expected", $time,
                     expected_triggers.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_round(input int a, input int b, input int c, input int d);
        t_round r;
        r.lane[0] = a[3:0];
        r.lane[1] = b[3:0];
        r.lane[2] = c[3:0];
        r.lane[3] = d[3:0];
        pending_rounds.push_back(r);
    endtask

    // Register writes happen only with the block idle; the predictor copy is
    // updated once the write strobe is lowered again.
    task automatic write_reg(input t_cfg_idx idx, input int data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ACTIVE:  cfg_active = data & 7;
            CFG_THRESH:  cfg_thresh = data & 7;
            CFG_NODE_ID: cfg_node   = data[9:0];
            default: ;
        endcase
    endtask

    // Wait until every queued round went in and every report came out, then
    // let the pipeline settle, since a round may cause no report at all.
    task automatic drain();
        while (pending_rounds.size() != 0 || in_ch.valid) @(negedge i_clk);
        while (expected_triggers.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Random rounds: mostly drawn from a small alphabet so that windows
    // agree often, the rest fully random.
    task automatic queue_random(input int count);
        int base;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) != 0) begin
                base = $urandom_range(0, 15);
                queue_round((base + $urandom_range(0, 1)) % 16,
                            (base + $urandom_range(0, 1)) % 16,
                            (base + $urandom_range(0, 2)) % 16,
                            (base + $urandom_range(0, 1)) % 16);
            end else begin
                queue_round($urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 15));
            end
        end
    endtask

    initial begin
        error_count = 0; rounds_accepted = 0; triggers_seen = 0; idle_cycles = 0;
        stim_done = 0; hold_req = 0; in_gap = 0; out_gap = 0;
        for (int i = 0; i < NEIGHBORS; i++) begin
            for (int v = 0; v < VALUE_COUNT; v++) lane_count[i][v] = 0;
            for (int s = 0; s < WINDOW_DEPTH; s++) win_hist[i][s] = '0;
        end
        next_slot = 0; hist_full = 0; round_idx = '0;
        cfg_active = 4; cfg_thresh = 3; cfg_node = '0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = CFG_ACTIVE; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.value_lane0 = '0; in_ch.value_lane1 = '0;
        in_ch.value_lane2 = '0; in_ch.value_lane3 = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rounds at reset settings: all agree, extremes of the
        // value range, all distinct, and enough rounds to wrap the window.
        queue_round(0, 0, 0, 0);
        queue_round(15, 15, 15, 15);
        queue_round(0, 15, 0, 15);
        queue_round(1, 2, 4, 8);
        queue_round(10, 5, 10, 5);
        queue_round(7, 7, 7, 3);
        queue_round(3, 12, 6, 9);
        queue_round(15, 0, 15, 0);
        queue_round(0, 0, 0, 0);
        queue_round(15, 15, 15, 15);
        drain();

        // A threshold of zero reports every distinct value; one lane only.
        write_reg(CFG_THRESH, 0);
        write_reg(CFG_ACTIVE, 1);
        write_reg(CFG_NODE_ID, 1023);
        queue_round(5, 6, 7, 8);
        queue_round(9, 9, 9, 9);
        drain();
        // No active lanes gives nothing; more lanes than present act as four.
        write_reg(CFG_ACTIVE, 0);
        queue_round(1, 1, 1, 1);
        drain();
        write_reg(CFG_ACTIVE, 7);
        write_reg(CFG_THRESH, 4);
        queue_round(2, 2, 2, 2);
        queue_round(2, 3, 4, 5);
        drain();
        // A threshold above the lane count never triggers.
        write_reg(CFG_ACTIVE, 2);
        write_reg(CFG_THRESH, 7);
        queue_round(4, 4, 4, 4);
        drain();

        // Long receiver stall while rounds keep coming: the block must fill
        // up and hold off its input.
        write_reg(CFG_ACTIVE, 4);
        write_reg(CFG_THRESH, 1);
        write_reg(CFG_NODE_ID, 341);
        hold_req++;
        queue_random(20);
        drain();

        // Random phases across several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_ACTIVE, $urandom_range(1, 4));
            write_reg(CFG_THRESH, $urandom_range(1, 4));
            write_reg(CFG_NODE_ID, $urandom_range(0, 1023));
            queue_random(45);
            drain();
        end

        stim_done = 1;
        $display("Ran %0d rounds and checked %0d trigger reports", rounds_accepted,
                 triggers_seen);
        $display("over lane counts, thresholds and node ids including the extremes.");
        if (error_count == 0 && expected_triggers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
